/* sv/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned NumW = 32;
  localparam int unsigned DenW = 31;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  // classified job from front to back, magnitudes and signs split out
  typedef struct packed {
    logic [2:0]  op;
    logic        skip;   // unused code or error, result known already
    logic [1:0]  status;
    logic        a_neg;
    logic [32:0] a_mag;
    logic [30:0] a_den;
    logic        b_neg;
    logic [32:0] b_mag;
    logic [30:0] b_den;
  } job_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
    logic        a_greater;
    logic        a_equal;
  } res_t;

endpackage

/* sv/rau_front.sv */
module rau_front
  import rau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [2:0]  req_type_i,
  input  logic [31:0] a_num_i,
  input  logic [30:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [30:0] b_den_i,
  output job_t        job_o
);

  logic [DATA_WIDTH-1:0] a_raw, b_raw;
  logic [32:0]           a_mag, b_mag;
  logic [30:0]           a_den, b_den;
  logic                  a_neg, b_neg;

  // take the low field bits, split sign and magnitude
  always_comb begin
    a_raw = a_num_i[DATA_WIDTH-1:0];
    b_raw = b_num_i[DATA_WIDTH-1:0];
    a_neg = a_raw[DATA_WIDTH-1];
    b_neg = b_raw[DATA_WIDTH-1];
    a_mag = a_neg ? 33'(-{1'b0, a_raw}) & {{(33-DATA_WIDTH){1'b0}}, {DATA_WIDTH{1'b1}}}
                  : 33'(a_raw);
    b_mag = b_neg ? 33'(-{1'b0, b_raw}) & {{(33-DATA_WIDTH){1'b0}}, {DATA_WIDTH{1'b1}}}
                  : 33'(b_raw);
    if (a_neg && a_mag == '0) a_mag = 33'(1) << (DATA_WIDTH - 1);
    if (b_neg && b_mag == '0) b_mag = 33'(1) << (DATA_WIDTH - 1);
    a_den = 31'(a_den_i[DATA_WIDTH-2:0]);
    b_den = 31'(b_den_i[DATA_WIDTH-2:0]);
  end

  // classify
  always_comb begin
    job_o        = '0;
    job_o.op     = req_type_i;
    job_o.a_neg  = a_neg;
    job_o.a_mag  = a_mag;
    job_o.a_den  = a_den;
    job_o.b_neg  = b_neg;
    job_o.b_mag  = b_mag;
    job_o.b_den  = b_den;
    job_o.status = ST_OK;
    if (req_type_i > OP_CMP) begin
      job_o.skip = 1'b1;
    end else if (a_den == '0 || (req_type_i != OP_NEG && b_den == '0) ||
                 (req_type_i == OP_DIV && b_mag == '0)) begin
      job_o.skip   = 1'b1;
      job_o.status = ST_DIVZ;
    end
  end

endmodule

/* sv/rau_queue.sv */
module rau_queue
  import rau_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_job_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_job_o   = mem_q[rd_q];

  // two-entry queue between front and back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (out_valid_o && out_ready_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wr_q] <= in_job_i;
  end

endmodule

/* sv/rau_back.sv */
module rau_back
  import rau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  output logic job_ready_o,
  input  job_t job_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_MUL3  = 9'b000001000,
    S_COMB  = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  localparam logic [63:0] Limit = 64'd1 << (DATA_WIDTH - 1);

  state_e      state_q, state_d;
  job_t        job_q;
  logic [63:0] t1_q, t2_q, dd_q;
  logic        neg_q;
  logic [63:0] nm_q, dn_q;      // value to reduce
  logic [63:0] gx_q, gy_q;      // gcd operands
  // shared remainder/quotient unit, one bit a cycle
  logic [63:0] dv_q, rem_q, quo_q;
  logic [6:0]  bit_q;
  logic        res_valid_q;
  res_t        res_q, res_d;

  logic [32:0] mx_a, mx_b;
  logic [63:0] prod;
  logic [64:0] trial;
  logic [63:0] rem_sh;
  logic        ln, rn;

  assign job_ready_o = state_q == S_IDLE && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // one 33x33 multiplier, shared across the three products
  always_comb begin
    mx_a = job_q.a_mag;
    mx_b = 33'(job_q.b_den);
    case (state_q)
      S_MUL1: begin
        mx_a = job_q.a_mag;
        mx_b = (job_q.op == OP_MUL) ? job_q.b_mag : 33'(job_q.b_den);
      end
      S_MUL2: begin
        mx_a = (job_q.op == OP_DIV) ? job_q.b_mag : 33'(job_q.b_den);
        mx_b = (job_q.op == OP_DIV || job_q.op == OP_MUL) ? 33'(job_q.a_den) : job_q.b_mag;
        if (job_q.op != OP_DIV && job_q.op != OP_MUL) mx_a = 33'(job_q.a_den);
      end
      S_MUL3: begin
        mx_a = 33'(job_q.a_den);
        mx_b = 33'(job_q.b_den);
      end
      default: ;
    endcase
    prod   = 64'(mx_a) * 64'(mx_b);
    rem_sh = {rem_q[62:0], dv_q[63]};
    trial  = {1'b0, rem_sh} - {1'b0, gy_q};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (job_valid_i && job_ready_o) state_d = job_i.skip ? S_OUT : S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_COMB;
      S_COMB: state_d = (job_q.op == OP_CMP) ? S_OUT : S_GCD;
      S_GCD:  if (bit_q == 7'd0 && gy_q == '0 && gx_q != '0) state_d = S_DIVN;
      S_DIVN: if (bit_q == 7'd64) state_d = S_DIVD;
      S_DIVD: if (bit_q == 7'd64) state_d = S_OUT;
      S_OUT:  if (!res_valid_q || res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // result word from the error status, the reduced value or the compare
  always_comb begin
    res_d = '0;
    ln    = job_q.a_neg && nm_q != '0;
    rn    = job_q.b_neg && t2_q != '0;
    if (job_q.skip) begin
      res_d.status = job_q.status;
    end else if (job_q.op == OP_CMP) begin
      if (ln != rn) begin
        res_d.a_greater = rn;
      end else begin
        res_d.a_equal   = nm_q == t2_q;
        res_d.a_greater = ln ? (nm_q < t2_q) : (nm_q > t2_q);
      end
    end else if (nm_q == '0) begin
      res_d.res_den = 31'd1;
    end else if (dn_q > Limit - 64'd1 ||
                 nm_q > (neg_q ? Limit : Limit - 64'd1)) begin
      res_d.status = ST_OVF;
    end else begin
      res_d.res_num = neg_q ? 32'(-nm_q) : 32'(nm_q);
      res_d.res_den = 31'(dn_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!res_valid_q || res_ready_i)) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          job_q <= job_i;
          nm_q  <= '0;
          dn_q  <= 64'd1;
          bit_q <= '0;
        end
      end
      S_MUL1: t1_q <= prod;
      S_MUL2: t2_q <= prod;
      S_MUL3: dd_q <= prod;
      S_COMB: begin
        bit_q <= '0;
        case (job_q.op)
          OP_ADD, OP_SUB: begin
            logic s2;
            s2 = (job_q.op == OP_SUB) ? !job_q.b_neg : job_q.b_neg;
            if (t2_q == '0) s2 = 1'b0;
            dn_q <= dd_q;
            if (job_q.a_neg == s2) begin
              neg_q <= job_q.a_neg; nm_q <= t1_q + t2_q;
            end else if (t1_q >= t2_q) begin
              neg_q <= job_q.a_neg; nm_q <= t1_q - t2_q;
            end else begin
              neg_q <= s2; nm_q <= t2_q - t1_q;
            end
          end
          OP_MUL, OP_DIV: begin
            neg_q <= job_q.a_neg != job_q.b_neg;
            nm_q  <= t1_q;
            dn_q  <= (job_q.op == OP_MUL) ? dd_q : t2_q;
          end
          OP_NEG: begin
            neg_q <= !job_q.a_neg;
            nm_q  <= 64'(job_q.a_mag);
            dn_q  <= 64'(job_q.a_den);
          end
          default: begin
            nm_q <= t1_q;   // compare keeps l in nm, r in t2
          end
        endcase
        gx_q <= '0;
        gy_q <= '0;
      end
      S_GCD: begin
        // euclid: each remainder by a bit-serial division
        if (bit_q == 7'd0) begin
          if (gx_q == '0 && gy_q == '0) begin
            gx_q <= nm_q; gy_q <= dn_q;
          end else if (gy_q != '0) begin
            dv_q  <= gx_q; rem_q <= '0; bit_q <= 7'd1;
          end
        end else begin
          dv_q <= {dv_q[62:0], 1'b0};
          rem_q <= trial[64] ? rem_sh : trial[63:0];
          if (bit_q == 7'd64) begin
            gx_q  <= gy_q;
            gy_q  <= trial[64] ? rem_sh : trial[63:0];
            bit_q <= '0;
          end else begin
            bit_q <= bit_q + 7'd1;
          end
        end
      end
      S_DIVN, S_DIVD: begin
        // divide value by gcd (held in gy_q after a swap)
        if (bit_q == 7'd0) begin
          gy_q  <= gx_q;
          dv_q  <= (state_q == S_DIVN) ? nm_q : dn_q;
          rem_q <= '0; quo_q <= '0; bit_q <= 7'd1;
        end else begin
          dv_q  <= {dv_q[62:0], 1'b0};
          rem_q <= trial[64] ? rem_sh : trial[63:0];
          quo_q <= {quo_q[62:0], !trial[64]};
          if (bit_q == 7'd64) begin
            if (state_q == S_DIVN) nm_q <= {quo_q[62:0], !trial[64]};
            else dn_q <= {quo_q[62:0], !trial[64]};
            bit_q <= '0;
          end else begin
            bit_q <= bit_q + 7'd1;
          end
        end
      end
      S_OUT: begin
        if (!res_valid_q || res_ready_i) res_q <= res_d;
      end
      default: ;
    endcase
  end

endmodule

/* sv/rational_arith_unit.sv */
// rational_arith_unit: exact add, subtract, multiply, divide, negate and
// compare on two fractions, each a signed numerator over a positive
// denominator. One request on the s_axis side gives one result on m_axis.
// s_axis_tdata carries req_type, a_num, a_den, b_num, b_den; m_axis_tdata
// carries res_num, res_den, status, a_greater, a_equal.
// The front decodes sign and magnitude and checks for zero divisors in the
// cycle of acceptance; a two-entry queue hands jobs to the back end.
// The back end forms cross products with one shared multiplier, then,
// except for a compare, reduces by a euclid gcd, each remainder taken by
// a bit-serial divider, then two more divisions by the gcd. Errored or
// unused codes go straight to the result. One request is worked on at a
// time. Reset clears the queue and the back end. When m_axis_tready is
// low the result holds in the output register; the queue keeps taking
// requests until it is full, then s_axis_tready drops.
module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[2:0], a_num[34:3], a_den[65:35], b_num[97:66], b_den[128:98]
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num[31:0], res_den[62:32], status[64:63], a_greater[65], a_equal[66]
  output logic [71:0]  m_axis_tdata
);

  job_t front_job, q_job;
  logic q_valid, q_ready;
  res_t res;

  rau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .req_type_i (s_axis_tdata[2:0]),
    .a_num_i    (s_axis_tdata[34:3]),
    .a_den_i    (s_axis_tdata[65:35]),
    .b_num_i    (s_axis_tdata[97:66]),
    .b_den_i    (s_axis_tdata[128:98]),
    .job_o      (front_job)
  );

  rau_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_job_i    (front_job),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_job_o   (q_job)
  );

  rau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {5'b0, res.a_equal, res.a_greater, res.status,
                         res.res_den, res.res_num};

`ifndef SYNTHESIS
  // a failed status never carries a value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status != ST_OK |-> res.res_num == '0 && res.res_den == '0)
    else $error("error result carries data");

  // greater and equal never both set
  a_cmp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(res.a_greater && res.a_equal))
    else $error("compare flags both set");

  // an ok arithmetic result with a nonzero numerator has a nonzero denominator
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.status == ST_OK && !res.a_greater && !res.a_equal &&
    res.res_num != '0 |-> res.res_den != '0)
    else $error("zero denominator on ok result");
`endif

endmodule
